/* rtl/skpf_pkg.sv */
package skpf_pkg;

  // Field widths
  localparam int unsigned POS_W  = 32;   // signed Q16.16
  localparam int unsigned COV_W  = 31;   // unsigned Q15.16
  localparam int unsigned GAIN_W = 16;   // unsigned Q0.16
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DATA_W = 32;

  // Serial datapath widths
  localparam int unsigned MCD_W  = 33;   // signed multiplicand
  localparam int unsigned MLT_W  = 31;   // unsigned multiplier, one bit per cycle
  localparam int unsigned ACC_W  = 34;   // upper accumulator half
  localparam int unsigned QUO_W  = 17;   // gain quotient before saturation
  localparam int unsigned CNT_W  = 5;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MLT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_INIT_POS = 3'd0;
  localparam logic [IDX_W-1:0] REG_VELOCITY = 3'd1;
  localparam logic [IDX_W-1:0] REG_INIT_COV = 3'd2;
  localparam logic [IDX_W-1:0] REG_PROC_NS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MEAS_NS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TSTEP    = 3'd5;

  // Register reset values
  localparam logic [POS_W-1:0] RST_INIT_POS = 32'sd0;
  localparam logic [POS_W-1:0] RST_VELOCITY = 32'd65536;
  localparam logic [COV_W-1:0] RST_INIT_COV = 31'd65536;
  localparam logic [COV_W-1:0] RST_PROC_NS  = 31'd6554;
  localparam logic [COV_W-1:0] RST_MEAS_NS  = 31'd32768;
  localparam logic [COV_W-1:0] RST_TSTEP    = 31'd65536;

  // Saturation limits and unity gain
  localparam logic [POS_W-1:0]  POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0]  POS_MIN  = 32'h8000_0000;
  localparam logic [COV_W-1:0]  COV_MAX  = 31'h7FFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;
  localparam logic [QUO_W-1:0]  Q_ONE    = 17'h1_0000;

  // Sequencer states
  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] ST_MUL_MOT  = 4'd1;
  localparam logic [ST_W-1:0] ST_PRED     = 4'd2;
  localparam logic [ST_W-1:0] ST_DIV_INIT = 4'd3;
  localparam logic [ST_W-1:0] ST_DIV      = 4'd4;
  localparam logic [ST_W-1:0] ST_KSET     = 4'd5;
  localparam logic [ST_W-1:0] ST_MUL_CORR = 4'd6;
  localparam logic [ST_W-1:0] ST_POS      = 4'd7;
  localparam logic [ST_W-1:0] ST_MUL_COV  = 4'd8;
  localparam logic [ST_W-1:0] ST_FIN      = 4'd9;

endpackage

/* rtl/scalar_kalman_position_filter.sv */
// Scalar constant-velocity Kalman position tracker, signed Q16.16. Every
// measurement beat runs one predict step (position += velocity*dt,
// covariance += Q) and one update step (gain = P/(P+R),
// position += gain*(z - position), P = (1-gain)*P); one result beat comes
// out for each measurement. Gain is unsigned Q0.16, forced to 0 when P+R is 0
// and capped at 65535 when R is 0. Results saturate to their field ranges.
// All arithmetic runs through one bit-serial shift-add multiplier (one
// multiplier bit per cycle) and a restoring divider (one quotient bit per
// cycle). The block works on one measurement at a time: each one passes
// through three serial products, one division and five further sequencer
// steps before its result is presented, and the next measurement is taken
// only once the sequencer is back at idle. A result sits in the output
// register until taken; the next measurement may be accepted meanwhile and
// its result waits in the last sequencer step. Writing initial_position or
// initial_covariance also reloads the tracker state. cfg_ready is high only
// while the block is idle, and a pending configuration write holds off the
// next measurement. Writes to unknown indexes are ignored, and value bits
// above a register's width drop.
module scalar_kalman_position_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  // measurement channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [skpf_pkg::POS_W-1:0]   in_measurement,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [skpf_pkg::POS_W-1:0]   out_position_estimate,
  output logic signed [skpf_pkg::POS_W-1:0]   out_velocity_estimate,
  output logic        [skpf_pkg::GAIN_W-1:0]  out_gain,
  output logic        [skpf_pkg::COV_W-1:0]   out_covariance,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [skpf_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [skpf_pkg::DATA_W-1:0]  cfg_data
);

  import skpf_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers and tracker state
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] vel_r;
  logic [COV_W-1:0] proc_ns_r;
  logic [COV_W-1:0] meas_ns_r;
  logic [COV_W-1:0] tstep_r;

  logic [POS_W-1:0] pos_r;      // position estimate
  logic [COV_W-1:0] unc_r;      // covariance

  // ---------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------
  logic [ST_W-1:0]   state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [POS_W-1:0]  meas_r;
  logic [POS_W-1:0]  xp_r;      // predicted position
  logic [COV_W-1:0]  pp_r;      // predicted covariance
  logic [POS_W-1:0]  xnew_r;    // updated position
  logic [GAIN_W-1:0] k_r;

  // serial multiplier: {hi_r, lo_r} shifts right one bit per cycle
  logic [MCD_W-1:0]  mcd_r, mcd_nxt;
  logic [ACC_W-1:0]  hi_r, hi_nxt;
  logic [MLT_W-1:0]  lo_r, lo_nxt;

  // restoring divider
  logic [MCD_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r, quo_nxt;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [POS_W-1:0]  out_vel_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic [COV_W-1:0]  out_cov_r;

  // ---------------------------------------------------------------------
  // Combinational datapath
  // ---------------------------------------------------------------------
  logic              in_beat;
  logic              cfg_beat;
  logic              out_load;
  logic [ACC_W-1:0]  mul_sum;
  logic [ACC_W+MLT_W-1:0] mul_full;
  logic [2*POS_W-1:0]     prod;
  logic [POS_W+17-1:0]    pos_sum;    // 49-bit: position + shifted product
  logic [POS_W-1:0]       pos_sat;
  logic [POS_W-1:0]       pp_sum;
  logic [COV_W-1:0]       pp_sat;
  logic                   div_ge;
  logic [MCD_W-1:0]       div_diff;
  logic [GAIN_W-1:0]      k_val;
  logic [MCD_W-1:0]       innov;
  logic [QUO_W-1:0]       one_minus_k;
  logic [COV_W-1:0]       pnew;

  // a waiting configuration write goes first
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_beat  = cfg_valid && cfg_ready;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // one shift-add step: add multiplicand if current multiplier bit set
  assign mul_sum  = hi_r + (lo_r[0] ? {mcd_r[MCD_W-1], mcd_r} : '0);
  assign mul_full = {hi_r, lo_r};
  assign prod     = mul_full[2*POS_W-1:0];

  // base + floor(prod / 2^16), saturated to signed 32 bits
  always_comb begin
    logic [POS_W-1:0] base;
    base = (state_r == ST_PRED) ? pos_r : xp_r;
    pos_sum = {{17{base[POS_W-1]}}, base} + {prod[2*POS_W-1], prod[2*POS_W-1:16]};
    if (pos_sum[POS_W+16:POS_W-1] == {18{pos_sum[POS_W+16]}}) begin
      pos_sat = pos_sum[POS_W-1:0];
    end else if (pos_sum[POS_W+16]) begin
      pos_sat = POS_MIN;
    end else begin
      pos_sat = POS_MAX;
    end
  end

  assign pp_sum = {1'b0, unc_r} + {1'b0, proc_ns_r};
  assign pp_sat = pp_sum[POS_W-1] ? COV_MAX : pp_sum[COV_W-1:0];

  assign div_ge   = (rem_r >= {1'b0, den_r});
  assign div_diff = rem_r - {1'b0, den_r};

  // zero denominator gives zero gain; R = 0 gives a quotient of 1.0, capped
  always_comb begin
    if (den_r == '0) begin
      k_val = '0;
    end else if (quo_r[QUO_W-1]) begin
      k_val = GAIN_MAX;
    end else begin
      k_val = quo_r[GAIN_W-1:0];
    end
  end

  assign innov       = {meas_r[POS_W-1], meas_r} - {xp_r[POS_W-1], xp_r};
  assign one_minus_k = Q_ONE - {1'b0, k_r};
  assign pnew        = (|prod[2*POS_W-1:COV_W+16]) ? COV_MAX : prod[COV_W+15:16];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mcd_nxt   = mcd_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          mcd_nxt   = {vel_r[POS_W-1], vel_r};
          hi_nxt    = '0;
          lo_nxt    = tstep_r;
          cnt_nxt   = MUL_LAST;
          state_nxt = ST_MUL_MOT;
        end
      end
      ST_MUL_MOT, ST_MUL_CORR, ST_MUL_COV: begin
        hi_nxt  = {mul_sum[ACC_W-1], mul_sum[ACC_W-1:1]};
        lo_nxt  = {mul_sum[0], lo_r[MLT_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          unique case (state_r)
            ST_MUL_MOT:  state_nxt = ST_PRED;
            ST_MUL_CORR: state_nxt = ST_POS;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_PRED: begin
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        rem_nxt   = {2'b00, pp_r};
        quo_nxt   = '0;
        cnt_nxt   = DIV_LAST;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = {(div_ge ? div_diff[MCD_W-2:0] : rem_r[MCD_W-2:0]), 1'b0};
        quo_nxt = {quo_r[QUO_W-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_KSET;
        end
      end
      ST_KSET: begin
        mcd_nxt   = innov;
        hi_nxt    = '0;
        lo_nxt    = {{(MLT_W-GAIN_W){1'b0}}, k_val};
        cnt_nxt   = MUL_LAST;
        state_nxt = ST_MUL_CORR;
      end
      ST_POS: begin
        mcd_nxt   = {2'b00, pp_r};
        hi_nxt    = '0;
        lo_nxt    = {{(MLT_W-QUO_W){1'b0}}, one_minus_k};
        cnt_nxt   = MUL_LAST;
        state_nxt = ST_MUL_COV;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration and tracker state; writes only land while idle, so they
  // never meet a state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r      <= RST_VELOCITY;
      proc_ns_r  <= RST_PROC_NS;
      meas_ns_r  <= RST_MEAS_NS;
      tstep_r    <= RST_TSTEP;
      pos_r      <= RST_INIT_POS;
      unc_r      <= RST_INIT_COV;
    end else begin
      if (out_load) begin
        pos_r <= xnew_r;
        unc_r <= pnew;
      end
      if (cfg_beat) begin
        unique case (cfg_index)
          REG_INIT_POS: pos_r     <= cfg_data;
          REG_VELOCITY: vel_r     <= cfg_data;
          REG_INIT_COV: unc_r     <= cfg_data[COV_W-1:0];
          REG_PROC_NS:  proc_ns_r <= cfg_data[COV_W-1:0];
          REG_MEAS_NS:  meas_ns_r <= cfg_data[COV_W-1:0];
          REG_TSTEP:    tstep_r   <= cfg_data[COV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    mcd_r <= mcd_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (in_beat) begin
      meas_r <= in_measurement;
    end
    if (state_r == ST_PRED) begin
      xp_r <= pos_sat;
      pp_r <= pp_sat;
    end
    if (state_r == ST_DIV_INIT) begin
      den_r <= {1'b0, pp_r} + {1'b0, meas_ns_r};
    end
    if (state_r == ST_KSET) begin
      k_r <= k_val;
    end
    if (state_r == ST_POS) begin
      xnew_r <= pos_sat;
    end
    if (out_load) begin
      out_pos_r  <= xnew_r;
      out_vel_r  <= vel_r;
      out_gain_r <= k_r;
      out_cov_r  <= pnew;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_position_estimate = out_pos_r;
  assign out_velocity_estimate = out_vel_r;
  assign out_gain              = out_gain_r;
  assign out_covariance        = out_cov_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a fresh result always comes with the sequencer back at idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == ST_IDLE))
    else $error("result loaded without returning to idle");

  // the update never grows the covariance beyond the predicted value
  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (pnew <= pp_r))
    else $error("updated covariance above predicted covariance");

  // zero denominator must give zero gain
  a_zero_den_gain: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_KSET) && (den_r == '0)) |=> (k_r == '0))
    else $error("nonzero gain with zero denominator");

  // no measurement is taken while one is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_IDLE) && (state_r != ST_MUL_MOT)) |=> (state_r != ST_MUL_MOT))
    else $error("new measurement started mid computation");

endmodule
